@@ sv/dpic_pkg.sv @@
// Shared types, codes and helpers for the dual interrupt controller model.
`timescale 1ns / 1ps
`default_nettype none
package dpic_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] OP_READ     = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_IRQ      = 3'd2;
    localparam logic [2:0] OP_MASK_SET = 3'd3;
    localparam logic [2:0] OP_REINIT   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_BASE  = 2'd3;

    localparam logic [7:0] MASTER_MASK_RST = 8'h7D;
    localparam logic [7:0] SLAVE_MASK_RST  = 8'h61;
    localparam logic [7:0] MASTER_BASE_RST = 8'h08;
    localparam logic [7:0] SLAVE_BASE_RST  = 8'h10;

    // ICW sequence positions
    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_ICW2 = 2'd1;
    localparam logic [1:0] STEP_ICW3 = 2'd2;
    localparam logic [1:0] STEP_ICW4 = 2'd3;

    localparam logic [7:0] BASE_MASK = 8'hF8;

    typedef struct packed {
        logic [2:0] operation;
        logic       chip;
        logic       port_sel;
        logic [7:0] write_data;
        logic [3:0] irq_line;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       inject;
        logic [7:0] vector;
        logic [7:0] mask_now;
        logic [7:0] request_now;
        logic [7:0] service_now;
    } out_item_t;

    typedef struct packed {
        logic [7:0] mask;
        logic [7:0] request;
        logic [7:0] service;
        logic [7:0] base;
        logic [1:0] init_step;
        logic       need_icw4;
        logic       single_mode;
        logic       read_service;
    } chip_state_t;

    function automatic chip_state_t init_state(input logic [7:0] mask, input logic [7:0] base);
        chip_state_t st;
        st              = '0;
        st.mask         = mask;
        st.base         = base;
        return st;
    endfunction

endpackage
`default_nettype wire

@@ sv/dual_pic_8259_model_top.sv @@
// Top level: cascaded pair of simplified interrupt controllers around a state memory.
// A transaction passes through the stage 1 registers and then the output register before its result shows on m_*.
// Throughput: one transaction per cycle while m_ready does not stall the output; the two-entry chip state
// memory is read on accept and written back from stage 1, with a write-to-read bypass for back-to-back access.
// Reset (aresetn, synchronous, active low): empties the pipeline, loads the init
// registers with their defaults and marks both chip entries as freshly initialized.
`timescale 1ns / 1ps
`default_nettype none
module dual_pic_8259_model_top import dpic_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire in_item_t             s_data,
    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      out_item_t            m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_wdata
);

    // Init registers (host-visible configuration)
    logic [7:0] cfg_mask_reg [2];
    logic [7:0] cfg_base_reg [2];

    // Values loaded by the last reinit; an entry whose valid bit is clear reads as these.
    logic [7:0] snap_mask_reg [2];
    logic [7:0] snap_base_reg [2];
    logic [1:0] ent_valid_reg;

    // Chip state memory, one entry per controller, registered read.
    chip_state_t state_mem [2];
    chip_state_t rd_data_reg;

    // Stage 1: the transaction whose state is being read back and updated.
    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        s1_addr_reg;
    logic        s1_ent_valid_reg;
    logic        byp_hit_reg;
    chip_state_t byp_data_reg;

    // Output register
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic        s_accept;
    logic        s1_adv;
    logic        s1_fire;
    logic        s1_is_reinit;
    logic        rd_addr;
    logic        byp_hit_next;
    chip_state_t byp_data_next;
    chip_state_t cur_state;
    chip_state_t reinit_state;
    chip_state_t nxt_state;
    out_item_t   step_res;

    // The selected chip comes from the line number for an IRQ, from the chip field otherwise.
    assign rd_addr  = (s_data.operation == OP_IRQ) ? s_data.irq_line[3] : s_data.chip;

    // Stage 1 may move on whenever the output register is free or is being drained.
    assign s1_adv   = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_ready  = aresetn && (!s1_valid_reg || s1_adv);
    assign s_accept = s_valid && s_ready;

    assign s1_is_reinit = (s1_item_reg.operation == OP_REINIT);

    // A reinit in stage 1 rewrites both entries; any other transaction rewrites its own.
    // A transaction read at the same edge sees that update through the bypass.
    assign byp_hit_next  = s1_fire && (s1_is_reinit || (s1_addr_reg == rd_addr));
    assign byp_data_next = s1_is_reinit ?
                           init_state(cfg_mask_reg[rd_addr], cfg_base_reg[rd_addr]) :
                           nxt_state;

    always_comb begin
        if (byp_hit_reg) begin
            cur_state = byp_data_reg;
        end else if (s1_ent_valid_reg) begin
            cur_state = rd_data_reg;
        end else begin
            cur_state = init_state(snap_mask_reg[s1_addr_reg], snap_base_reg[s1_addr_reg]);
        end
    end

    assign reinit_state = init_state(cfg_mask_reg[s1_addr_reg], cfg_base_reg[s1_addr_reg]);

    dpic_step u_step (
        .item      (s1_item_reg),
        .cur       (cur_state),
        .reinit_st (reinit_state),
        .nxt       (nxt_state),
        .res       (step_res)
    );

    // Init register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mask_reg[0] <= MASTER_MASK_RST;
            cfg_mask_reg[1] <= SLAVE_MASK_RST;
            cfg_base_reg[0] <= MASTER_BASE_RST;
            cfg_base_reg[1] <= SLAVE_BASE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MASTER_MASK: cfg_mask_reg[0] <= cfg_wdata;
                CFG_SLAVE_MASK:  cfg_mask_reg[1] <= cfg_wdata;
                CFG_MASTER_BASE: cfg_base_reg[0] <= cfg_wdata;
                CFG_SLAVE_BASE:  cfg_base_reg[1] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Reinit bookkeeping: clear valid bits and capture init values; other transactions set their own bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg    <= '0;
            snap_mask_reg[0] <= MASTER_MASK_RST;
            snap_mask_reg[1] <= SLAVE_MASK_RST;
            snap_base_reg[0] <= MASTER_BASE_RST;
            snap_base_reg[1] <= SLAVE_BASE_RST;
        end else if (s1_fire) begin
            if (s1_is_reinit) begin
                ent_valid_reg <= '0;
                snap_mask_reg <= cfg_mask_reg;
                snap_base_reg <= cfg_base_reg;
            end else begin
                ent_valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    // State memory: write-back from stage 1, read on accept.
    always_ff @(posedge aclk) begin
        if (s1_fire && !s1_is_reinit) begin
            state_mem[s1_addr_reg] <= nxt_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= state_mem[rd_addr];
        end
    end

    // Stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg      <= s_data;
            s1_addr_reg      <= rd_addr;
            s1_ent_valid_reg <= ent_valid_reg[rd_addr];
            byp_hit_reg      <= byp_hit_next;
            byp_data_reg     <= byp_data_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg <= step_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

@@ sv/dpic_step.sv @@
// Per-transaction state update and result for one controller.
`timescale 1ns / 1ps
`default_nettype none
module dpic_step import dpic_pkg::*; (
    input  in_item_t    item,
    input  chip_state_t cur,
    input  chip_state_t reinit_st,
    output chip_state_t nxt,
    output out_item_t   res
);

    logic [7:0] v;
    logic [7:0] irq_bit;
    logic [7:0] eoi_bit;

    assign v       = item.write_data;
    assign irq_bit = 8'd1 << item.irq_line[2:0];
    assign eoi_bit = 8'd1 << v[2:0];

    always_comb begin
        nxt           = cur;
        res           = '0;
        case (item.operation)
            OP_READ: begin
                if (item.port_sel) begin
                    res.read_data = cur.mask;
                end else begin
                    res.read_data = cur.read_service ? cur.service : cur.request;
                end
            end
            OP_WRITE: begin
                if (item.port_sel) begin
                    case (cur.init_step)
                        STEP_ICW2: begin
                            nxt.base = v & BASE_MASK;
                            if (cur.single_mode) begin
                                nxt.init_step = cur.need_icw4 ? STEP_ICW4 : STEP_IDLE;
                            end else begin
                                nxt.init_step = STEP_ICW3;
                            end
                        end
                        STEP_ICW3: nxt.init_step = cur.need_icw4 ? STEP_ICW4 : STEP_IDLE;
                        STEP_ICW4: nxt.init_step = STEP_IDLE;
                        default:   nxt.mask = v;
                    endcase
                end else if (v[4]) begin
                    // ICW1
                    nxt.init_step    = STEP_ICW2;
                    nxt.need_icw4    = v[0];
                    nxt.single_mode  = v[1];
                    nxt.service      = '0;
                    nxt.request      = '0;
                    nxt.read_service = 1'b0;
                end else if (v[3]) begin
                    // OCW3
                    if (v[1]) begin
                        nxt.read_service = v[0];
                    end
                end else if (v[6] && v[5]) begin
                    nxt.service = cur.service & ~eoi_bit;
                end else if (v[5]) begin
                    nxt.service = cur.service & (cur.service - 8'd1);
                end
            end
            OP_IRQ: begin
                if ((cur.mask & irq_bit) == 8'd0) begin
                    nxt.request = cur.request & ~irq_bit;
                    nxt.service = cur.service | irq_bit;
                    res.inject  = 1'b1;
                    res.vector  = cur.base + {5'd0, item.irq_line[2:0]};
                end else begin
                    nxt.request = cur.request | irq_bit;
                end
            end
            OP_MASK_SET: nxt.mask = v;
            OP_REINIT:   nxt = reinit_st;
            default:     nxt = cur;
        endcase
        res.mask_now    = nxt.mask;
        res.request_now = nxt.request;
        res.service_now = nxt.service;
    end

endmodule
`default_nettype wire

@@ sv/dpic_checker.sv @@
// Port-level assertions for the controller pair, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dpic_checker import dpic_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // No vector without a delivered interrupt, and no read data with one.
    a_vec_inject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.inject |-> m_data.vector == 8'd0)
        else $error("vector without inject");

    a_inject_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.inject |-> m_data.read_data == 8'd0)
        else $error("read data on an irq transaction");

    // A fresh result comes from an accepted transaction that passed through stage 1.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching transaction");

endmodule

bind dual_pic_8259_model_top dpic_checker u_dpic_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
